@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/scr_pkg.sv @@
package scr_pkg;

	localparam int CHANNELS    = 2;
	localparam int SAMPLE_BITS = 12;
	localparam int PIN_BITS    = 12;
	localparam int BIAS_BITS   = 12;
	localparam int PERIOD_BITS = 7;
	localparam int LED_BITS    = 8;
	// Threshold sums need two bits above the wider of sample and bias.
	localparam int SUM_W = ((SAMPLE_BITS > BIAS_BITS) ? SAMPLE_BITS : BIAS_BITS) + 2;

	localparam logic [BIAS_BITS-1:0]   BIAS_RESET   = BIAS_BITS'(248);
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(100);

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_END    = 2'd1,
		OP_TICK   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		DIR_CENTRE = 2'd0,
		DIR_UP     = 2'd1,
		DIR_DOWN   = 2'd2
	} dir_t;

	typedef enum logic {
		REG_BIAS   = 1'b0,
		REG_PERIOD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic sample_en;
		logic end_en;
		logic seen;
	} lane_ctrl_t;

	typedef struct packed {
		logic                fire;
		logic                forced;
		logic [PIN_BITS-1:0] buttons;
		dir_t                dir_x;
		dir_t                dir_y;
	} report_t;

endpackage

@@ src/stick_calibrate_and_report_core.sv @@
// Analog stick and button conditioner.
// Input beats (in_valid/in_ready) carry an opcode, two 12-bit axis samples and
// twelve button pin levels. While calibrating, sample beats update each axis's
// peak high, peak low and running mean; an end beat stores each axis spread and
// switches to running. In running, each check tick classifies both axes as up,
// down or centre and sends a report beat (out_valid/out_ready) when the buttons
// or a direction changed, or when the heartbeat counter reaches its period.
// Beats with an opcode that does not fit the phase are accepted and dropped.
// One input beat is taken every cycle unless an untaken report holds the
// output register. The axis lanes classify in the accept cycle into a stage
// register, the merge stage decides from that register, and the report is
// then captured in the output register, where it waits to be taken.
// The output register is the only buffer: while it holds an untaken report,
// in_ready is low and the pipeline holds; when it is taken, the next beat
// flows in the same cycle. Reset (arst_n low) returns the block to
// calibration, clears all history and restores the two APB registers
// (dead band bias at address 0, heartbeat period at address 4).
`include "assert_macros.svh"

module stick_calibrate_and_report_core
	import scr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [11:0]          sample_x,
	input  logic [11:0]          sample_y,
	input  logic [PIN_BITS-1:0]  button_pins,
	// Output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIN_BITS-1:0]  buttons,
	output logic [1:0]           dir_x,
	output logic [1:0]           dir_y,
	output logic [LED_BITS-1:0]  led_pattern,
	output logic                 forced
);

	// Configuration registers. pready is tied high, so no access is held
	// in wait states.
	logic [BIAS_BITS-1:0]   bias_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic                   cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q   <= BIAS_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_BIAS:   bias_q   <= pwdata[BIAS_BITS-1:0];
				REG_PERIOD: period_q <= pwdata[PERIOD_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_BIAS:   prdata = 32'(bias_q);
			REG_PERIOD: prdata = 32'(period_q);
			default:    prdata = '0;
		endcase
	end

	// Flow control: everything advances whenever the output register is free
	// or is being emptied in this cycle.
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	// Phase tracking. The block leaves calibration once and never returns
	// short of a reset.
	logic       phase_q;
	logic       seen_q;
	logic       cal_sample;
	logic       cal_end;
	logic       run_tick;
	lane_ctrl_t lane_ctrl;

	assign cal_sample = accept && !phase_q && (opcode == OP_SAMPLE);
	assign cal_end    = accept && !phase_q && (opcode == OP_END);
	assign run_tick   = accept && phase_q && (opcode == OP_TICK);

	assign lane_ctrl.sample_en = cal_sample;
	assign lane_ctrl.end_en    = cal_end;
	assign lane_ctrl.seen      = seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			if (cal_end) phase_q <= 1'b1;
			if (cal_sample) seen_q <= 1'b1;
		end
	end

	// One lane per axis. Axes past the second have no input and read zero.
	sample_t [CHANNELS-1:0] lane_sample;
	dir_t    [CHANNELS-1:0] lane_dir;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			lane_sample[i] = '0;
		end
		lane_sample[0] = sample_t'(sample_x);
		if (CHANNELS > 1) lane_sample[CHANNELS > 1 ? 1 : 0] = sample_t'(sample_y);
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		scr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.sample (lane_sample[g]),
			.bias   (bias_q),
			.dir    (lane_dir[g])
		);
	end

	// Stage register between the lanes and the merge logic.
	logic                tick_s1;
	dir_t [CHANNELS-1:0] dir_s1;
	logic [PIN_BITS-1:0] pins_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_s1 <= 1'b0;
		end else if (advance) begin
			tick_s1 <= run_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dir_s1  <= lane_dir;
			pins_s1 <= button_pins;
		end
	end

	// Merge stage: change detection and the heartbeat counter.
	report_t report;

	scr_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_s1 && advance),
		.dirs   (dir_s1),
		.pins   (pins_s1),
		.period (period_q),
		.report (report)
	);

	// Output register.
	logic [PIN_BITS-1:0] buttons_q;
	dir_t                dir_x_q;
	dir_t                dir_y_q;
	logic                forced_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= report.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && report.fire) begin
			buttons_q <= report.buttons;
			dir_x_q   <= report.dir_x;
			dir_y_q   <= report.dir_y;
			forced_q  <= report.forced;
		end
	end

	assign out_valid   = out_valid_q;
	assign buttons     = buttons_q;
	assign dir_x       = dir_x_q;
	assign dir_y       = dir_y_q;
	assign led_pattern = ~buttons_q[LED_BITS-1:0];
	assign forced      = forced_q;

	`ASSERT_NEXT(a_phase_sticky, clk, arst_n, phase_q, phase_q)
	`ASSERT_SAME(a_tick_in_running, clk, arst_n, tick_s1, phase_q)
	`ASSERT_SAME(a_report_from_tick, clk, arst_n, $rose(out_valid_q), $past(tick_s1))
	`ASSERT_SAME(a_no_accept_when_full, clk, arst_n, out_valid_q && !out_ready, !in_ready)

endmodule

@@ src/scr_lane.sv @@
module scr_lane
	import scr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  lane_ctrl_t           ctrl,
	input  sample_t              sample,
	input  logic [BIAS_BITS-1:0] bias,
	output dir_t                 dir
);

	sample_t peak_high_q;
	sample_t peak_low_q;
	sample_t mean_q;
	sample_t spread_q;

	logic [SAMPLE_BITS:0] mean_sum;
	logic [SUM_W-1:0]     up_thr;
	logic [SUM_W-1:0]     down_lhs;
	logic                 is_up;
	logic                 is_down;

	assign mean_sum = {1'b0, mean_q} + {1'b0, sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_high_q <= '0;
			peak_low_q  <= '1;
			mean_q      <= '0;
			spread_q    <= '0;
		end else if (ctrl.sample_en) begin
			if (sample > peak_high_q) peak_high_q <= sample;
			if (sample < peak_low_q) peak_low_q <= sample;
			mean_q <= (mean_q != '0) ? mean_sum[SAMPLE_BITS:1] : sample;
		end else if (ctrl.end_en) begin
			if (ctrl.seen && (peak_high_q >= peak_low_q)) begin
				spread_q <= peak_high_q - peak_low_q;
			end else begin
				spread_q <= '0;
			end
		end
	end

	// The down test s <= mean - spread - bias is rearranged so that it stays unsigned.
	assign up_thr   = SUM_W'(mean_q) + SUM_W'(spread_q) + SUM_W'(bias);
	assign down_lhs = SUM_W'(sample) + SUM_W'(spread_q) + SUM_W'(bias);
	assign is_up    = SUM_W'(sample) >= up_thr;
	assign is_down  = down_lhs <= SUM_W'(mean_q);

	assign dir = is_up ? DIR_UP : (is_down ? DIR_DOWN : DIR_CENTRE);

endmodule

@@ src/scr_merge.sv @@
module scr_merge
	import scr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  dir_t [CHANNELS-1:0]    dirs,
	input  logic [PIN_BITS-1:0]    pins,
	input  logic [PERIOD_BITS-1:0] period,
	output report_t                report
);

	logic [PIN_BITS-1:0]    last_buttons_q;
	dir_t [CHANNELS-1:0]    last_dir_q;
	logic [PERIOD_BITS-1:0] tick_count_q;

	logic                   changed;
	logic [PERIOD_BITS-1:0] count_next;
	logic                   fire;

	always_comb begin
		changed = (pins != last_buttons_q);
		for (int i = 0; i < CHANNELS; i++) begin
			if (dirs[i] != last_dir_q[i]) changed = 1'b1;
		end
	end

	assign count_next = tick_count_q + PERIOD_BITS'(1);
	assign fire       = changed || (count_next == period);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buttons_q <= '0;
			last_dir_q     <= {CHANNELS{DIR_CENTRE}};
			tick_count_q   <= '0;
		end else if (tick) begin
			last_buttons_q <= pins;
			last_dir_q     <= dirs;
			tick_count_q   <= fire ? '0 : count_next;
		end
	end

	always_comb begin
		report.fire    = tick && fire;
		report.forced  = !changed;
		report.buttons = pins;
		report.dir_x   = dirs[0];
		report.dir_y   = DIR_CENTRE;
		if (CHANNELS > 1) report.dir_y = dirs[CHANNELS > 1 ? 1 : 0];
	end

endmodule
